### src/crs_pkg.sv
// Shared types and constants for the clip rectangle stack.
`default_nettype none
package crs_pkg;

	// Stack geometry.
	localparam int STACK_DEPTH = 16;
	localparam int IDX_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	// Field widths.
	localparam int COORD_W = 32;
	localparam int CLIP_W  = 14;
	localparam int DEPTH_W = 5;
	localparam int CFG_W   = 32;

	// Reset screen size.
	localparam logic [CLIP_W-1:0] SCREEN_W_RST = CLIP_W'(320);
	localparam logic [CLIP_W-1:0] SCREEN_H_RST = CLIP_W'(240);

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_RESET = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CFG_CAMERA_X      = 2'd0,
		CFG_CAMERA_Y      = 2'd1,
		CFG_SCREEN_WIDTH  = 2'd2,
		CFG_SCREEN_HEIGHT = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		ST_DONE = 1'b0,
		ST_FULL = 1'b1
	} status_t;

	typedef struct packed {
		logic [CLIP_W-1:0] left;
		logic [CLIP_W-1:0] top;
		logic [CLIP_W-1:0] width;
		logic [CLIP_W-1:0] height;
	} clip_t;

endpackage
`default_nettype wire

### src/clip_rect_stack_core.sv
// Clip rectangle stack: camera shift, screen and top-of-stack intersection, stack storage.
`default_nettype none
// Channel   Handshake                   Payload
// --------  --------------------------  ----------------------------------------------
// item      item_valid / item_stall     opcode, rect_left, rect_top, rect_width,
//                                       rect_height
// result    result_valid / result_stall clip_left, clip_top, clip_width, clip_height,
//                                       depth, status
// config    cfg_we (no handshake back)  cfg_index, cfg_data
//
// Each item is registered straight into the result register, so one item can transfer
// every cycle while result_stall is low. The critical path is the 33-bit camera subtract,
// saturation, edge add and compare, followed by the 15-bit intersection with the top.
// Reset leaves the stack empty (depth 0, top clip all zero) and the registers at their
// defaults. item_stall follows result_stall while a result is held; the stack entries
// live in flip-flops with the current top held in its own register.
module clip_rect_stack_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration
	input  wire logic                                cfg_we,
	input  wire logic [1:0]                          cfg_index,
	input  wire logic [crs_pkg::CFG_W-1:0]           cfg_data,
	// item channel
	input  wire logic                                item_valid,
	output logic                                     item_stall,
	input  wire logic [1:0]                          opcode,
	input  wire logic signed [crs_pkg::COORD_W-1:0]  rect_left,
	input  wire logic signed [crs_pkg::COORD_W-1:0]  rect_top,
	input  wire logic signed [crs_pkg::COORD_W-1:0]  rect_width,
	input  wire logic signed [crs_pkg::COORD_W-1:0]  rect_height,
	// result channel
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output logic [crs_pkg::CLIP_W-1:0]               clip_left,
	output logic [crs_pkg::CLIP_W-1:0]               clip_top,
	output logic [crs_pkg::CLIP_W-1:0]               clip_width,
	output logic [crs_pkg::CLIP_W-1:0]               clip_height,
	output logic [crs_pkg::DEPTH_W-1:0]              depth,
	output logic                                     status
);

	localparam int CW = crs_pkg::CLIP_W;

	// Configuration registers.
	logic signed [crs_pkg::COORD_W-1:0] camera_x_q;
	logic signed [crs_pkg::COORD_W-1:0] camera_y_q;
	logic [CW-1:0]                      screen_w_q;
	logic [CW-1:0]                      screen_h_q;

	// Stack state: entries plus a copy of the current top (zero when empty).
	crs_pkg::clip_t                     entries_q [crs_pkg::STACK_DEPTH];
	crs_pkg::clip_t                     top_q;
	logic [crs_pkg::CNT_W-1:0]          count_q;

	// Result register.
	logic                               result_valid_q;
	crs_pkg::clip_t                     result_clip_q;
	logic [crs_pkg::DEPTH_W-1:0]        result_depth_q;
	logic                               result_status_q;

	logic                               item_xfer;

	// Hold the item whenever a result waits and downstream stalls.
	assign item_stall = result_valid_q && result_stall;
	assign item_xfer  = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			camera_x_q <= '0;
			camera_y_q <= '0;
			screen_w_q <= crs_pkg::SCREEN_W_RST;
			screen_h_q <= crs_pkg::SCREEN_H_RST;
		end else if (cfg_we) begin
			case (crs_pkg::cfg_idx_t'(cfg_index))
				crs_pkg::CFG_CAMERA_X:      camera_x_q <= cfg_data;
				crs_pkg::CFG_CAMERA_Y:      camera_y_q <= cfg_data;
				crs_pkg::CFG_SCREEN_WIDTH:  screen_w_q <= cfg_data[CW-1:0];
				crs_pkg::CFG_SCREEN_HEIGHT: screen_h_q <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Push geometry: camera shift with saturation to 32-bit signed.
	// ---------------------------------------------------------------------
	localparam int COORD_W_P1 = crs_pkg::COORD_W + 1;
	logic signed [COORD_W_P1-1:0] dx, dy;
	logic signed [crs_pkg::COORD_W-1:0] sat_x, sat_y;

	function automatic logic signed [crs_pkg::COORD_W-1:0] sat_coord(
		input logic signed [crs_pkg::COORD_W:0] v
	);
		logic [1:0] hi;
		hi = v[crs_pkg::COORD_W:crs_pkg::COORD_W-1];
		case (hi)
			2'b01:   sat_coord = {1'b0, {(crs_pkg::COORD_W-1){1'b1}}};
			2'b10:   sat_coord = {1'b1, {(crs_pkg::COORD_W-1){1'b0}}};
			default: sat_coord = v[crs_pkg::COORD_W-1:0];
		endcase
	endfunction

	assign dx    = COORD_W_P1'(rect_left) - COORD_W_P1'(camera_x_q);
	assign dy    = COORD_W_P1'(rect_top)  - COORD_W_P1'(camera_y_q);
	assign sat_x = sat_coord(dx);
	assign sat_y = sat_coord(dy);

	// Screen intersection in 34-bit signed, where origin plus extent cannot overflow.
	localparam int EW = crs_pkg::COORD_W + 2;
	logic signed [EW-1:0] x_e, y_e, w_e, h_e, sw_e, sh_e;
	logic signed [EW-1:0] l1, t1, r1, b1, x_end, y_end;
	logic                 empty1;
	crs_pkg::clip_t       rect1;

	assign x_e  = EW'(sat_x);
	assign y_e  = EW'(sat_y);
	// Drop negative extents to zero.
	assign w_e  = rect_width[crs_pkg::COORD_W-1]  ? '0 : EW'(rect_width);
	assign h_e  = rect_height[crs_pkg::COORD_W-1] ? '0 : EW'(rect_height);
	assign sw_e = $signed({{(EW-CW){1'b0}}, screen_w_q});
	assign sh_e = $signed({{(EW-CW){1'b0}}, screen_h_q});

	assign x_end  = x_e + w_e;
	assign y_end  = y_e + h_e;
	assign l1     = (x_e > 0) ? x_e : '0;
	assign t1     = (y_e > 0) ? y_e : '0;
	assign r1     = (x_end < sw_e) ? x_end : sw_e;
	assign b1     = (y_end < sh_e) ? y_end : sh_e;
	assign empty1 = (r1 <= l1) || (b1 <= t1);

	always_comb begin
		rect1 = '0;
		if (!empty1) begin
			rect1.left   = l1[CW-1:0];
			rect1.top    = t1[CW-1:0];
			rect1.width  = CW'(r1 - l1);
			rect1.height = CW'(b1 - t1);
		end
	end

	// Intersection with the current top; all values are non-negative 14-bit.
	logic [CW:0]    l2, t2, r2, b2, ra, rb, ba, bb;
	logic           empty2;
	crs_pkg::clip_t rect2, push_rect;

	assign ra = {1'b0, rect1.left} + {1'b0, rect1.width};
	assign rb = {1'b0, top_q.left} + {1'b0, top_q.width};
	assign ba = {1'b0, rect1.top}  + {1'b0, rect1.height};
	assign bb = {1'b0, top_q.top}  + {1'b0, top_q.height};
	assign l2 = (rect1.left > top_q.left) ? {1'b0, rect1.left} : {1'b0, top_q.left};
	assign t2 = (rect1.top  > top_q.top)  ? {1'b0, rect1.top}  : {1'b0, top_q.top};
	assign r2 = (ra < rb) ? ra : rb;
	assign b2 = (ba < bb) ? ba : bb;
	assign empty2 = (r2 <= l2) || (b2 <= t2);

	always_comb begin
		rect2 = '0;
		if (!empty2) begin
			rect2.left   = l2[CW-1:0];
			rect2.top    = t2[CW-1:0];
			rect2.width  = CW'(r2 - l2);
			rect2.height = CW'(b2 - t2);
		end
	end

	// An empty stack clips only against the screen.
	assign push_rect = (count_q == '0) ? rect1 : rect2;

	// ---------------------------------------------------------------------
	// Stack update.
	// ---------------------------------------------------------------------
	crs_pkg::clip_t            full_rect, below_rect, top_d;
	logic [crs_pkg::CNT_W-1:0] count_d;
	logic                      status_d;
	logic                      wr_en;
	logic [crs_pkg::IDX_W-1:0] wr_idx, below_idx;
	crs_pkg::clip_t            wr_data;

	assign full_rect  = '{left: '0, top: '0, width: screen_w_q, height: screen_h_q};
	assign below_idx  = crs_pkg::IDX_W'(count_q - crs_pkg::CNT_W'(2));
	assign below_rect = entries_q[below_idx];

	always_comb begin
		top_d    = top_q;
		count_d  = count_q;
		status_d = crs_pkg::ST_DONE;
		wr_en    = 1'b0;
		wr_idx   = crs_pkg::IDX_W'(count_q);
		wr_data  = push_rect;
		case (crs_pkg::op_t'(opcode))
			crs_pkg::OP_PUSH: begin
				if (count_q >= crs_pkg::CNT_W'(crs_pkg::STACK_DEPTH)) begin
					status_d = crs_pkg::ST_FULL;
				end else begin
					wr_en   = 1'b1;
					top_d   = push_rect;
					count_d = count_q + crs_pkg::CNT_W'(1);
				end
			end
			crs_pkg::OP_POP: begin
				// Keep the base entry.
				if (count_q > crs_pkg::CNT_W'(1)) begin
					top_d   = below_rect;
					count_d = count_q - crs_pkg::CNT_W'(1);
				end
			end
			crs_pkg::OP_RESET: begin
				wr_en   = 1'b1;
				wr_idx  = '0;
				wr_data = full_rect;
				top_d   = full_rect;
				count_d = crs_pkg::CNT_W'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (item_xfer && wr_en) begin
			entries_q[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			top_q   <= '0;
		end else if (item_xfer) begin
			count_q <= count_d;
			top_q   <= top_d;
		end
	end

	// Result register: load on transfer in, drop valid when taken downstream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (item_xfer) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			result_clip_q   <= top_d;
			result_depth_q  <= crs_pkg::DEPTH_W'(count_d);
			result_status_q <= status_d;
		end
	end

	assign result_valid = result_valid_q;
	assign clip_left    = result_clip_q.left;
	assign clip_top     = result_clip_q.top;
	assign clip_width   = result_clip_q.width;
	assign clip_height  = result_clip_q.height;
	assign depth        = result_depth_q;
	assign status       = result_status_q;

endmodule
`default_nettype wire

### dv/clip_rect_stack_checker.sv
// Checker for the clip rectangle stack: tracks registers and stack, compares every result.
module clip_rect_stack_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [1:0]                          cfg_index,
	input  wire logic [crs_pkg::CFG_W-1:0]           cfg_data,
	input  wire logic                                item_valid,
	input  wire logic                                item_stall,
	input  wire logic [1:0]                          opcode,
	input  wire logic signed [crs_pkg::COORD_W-1:0]  rect_left,
	input  wire logic signed [crs_pkg::COORD_W-1:0]  rect_top,
	input  wire logic signed [crs_pkg::COORD_W-1:0]  rect_width,
	input  wire logic signed [crs_pkg::COORD_W-1:0]  rect_height,
	input  wire logic                                result_valid,
	input  wire logic                                result_stall,
	input  wire logic [crs_pkg::CLIP_W-1:0]          clip_left,
	input  wire logic [crs_pkg::CLIP_W-1:0]          clip_top,
	input  wire logic [crs_pkg::CLIP_W-1:0]          clip_width,
	input  wire logic [crs_pkg::CLIP_W-1:0]          clip_height,
	input  wire logic [crs_pkg::DEPTH_W-1:0]         depth,
	input  wire logic                                status,
	output int                                       errors,
	output int                                       outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;

	typedef struct {
		longint x;
		longint y;
		longint w;
		longint h;
	} box_t;

	typedef struct packed {
		crs_pkg::clip_t                clip;
		logic [crs_pkg::DEPTH_W-1:0]   depth;
		logic                          refused;
	} clip_outcome_t;

	logic signed [crs_pkg::COORD_W-1:0] cam_x = '0;
	logic signed [crs_pkg::COORD_W-1:0] cam_y = '0;
	logic [crs_pkg::CLIP_W-1:0]         scr_w = crs_pkg::SCREEN_W_RST;
	logic [crs_pkg::CLIP_W-1:0]         scr_h = crs_pkg::SCREEN_H_RST;
	crs_pkg::clip_t                     clip_stack [crs_pkg::STACK_DEPTH];
	int                                 stack_count = 0;
	clip_outcome_t                      pending_clips [$];
	int                                 fail_count = 0;
	int                                 pending_count = 0;

	assign errors      = fail_count;
	assign outstanding = pending_count;

	function automatic longint shift_sat(logic signed [crs_pkg::COORD_W-1:0] pos,
			logic signed [crs_pkg::COORD_W-1:0] cam);
		longint d;
		d = longint'(pos) - longint'(cam);
		if (d < SAT_LO) return SAT_LO;
		if (d > SAT_HI) return SAT_HI;
		return d;
	endfunction

	function automatic box_t as_box(crs_pkg::clip_t c);
		box_t b;
		b.x = longint'(c.left);
		b.y = longint'(c.top);
		b.w = longint'(c.width);
		b.h = longint'(c.height);
		return b;
	endfunction

	// Intersect two boxes; negative extents count as zero, no overlap gives all zero.
	function automatic box_t overlap(box_t a, box_t b);
		box_t   r;
		longint lft, tp, ra, rb, ba, bb, rgt, btm;
		r   = '{0, 0, 0, 0};
		lft = (a.x > b.x) ? a.x : b.x;
		tp  = (a.y > b.y) ? a.y : b.y;
		ra  = a.x + ((a.w > 0) ? a.w : 0);
		rb  = b.x + ((b.w > 0) ? b.w : 0);
		ba  = a.y + ((a.h > 0) ? a.h : 0);
		bb  = b.y + ((b.h > 0) ? b.h : 0);
		rgt = (ra < rb) ? ra : rb;
		btm = (ba < bb) ? ba : bb;
		if (rgt <= lft || btm <= tp) return r;
		r.x = lft;
		r.y = tp;
		r.w = rgt - lft;
		r.h = btm - tp;
		return r;
	endfunction

	// Advance the stack by one item and return the result it produces.
	function automatic clip_outcome_t apply_clip_op(logic [1:0] op,
			logic signed [crs_pkg::COORD_W-1:0] l, logic signed [crs_pkg::COORD_W-1:0] t,
			logic signed [crs_pkg::COORD_W-1:0] w, logic signed [crs_pkg::COORD_W-1:0] h);
		clip_outcome_t o;
		box_t          r;
		box_t          scr;
		o   = '0;
		scr = '{0, 0, longint'(scr_w), longint'(scr_h)};
		case (op)
			crs_pkg::OP_PUSH: begin
				if (stack_count >= crs_pkg::STACK_DEPTH) begin
					o.refused = crs_pkg::ST_FULL;
				end else begin
					r.x = shift_sat(l, cam_x);
					r.y = shift_sat(t, cam_y);
					r.w = longint'(w);
					r.h = longint'(h);
					r   = overlap(r, scr);
					if (stack_count > 0) r = overlap(r, as_box(clip_stack[stack_count-1]));
					clip_stack[stack_count] = '{left: crs_pkg::CLIP_W'(r.x),
						top: crs_pkg::CLIP_W'(r.y), width: crs_pkg::CLIP_W'(r.w),
						height: crs_pkg::CLIP_W'(r.h)};
					stack_count++;
				end
			end
			crs_pkg::OP_POP: begin
				if (stack_count > 1) stack_count--;
			end
			crs_pkg::OP_RESET: begin
				stack_count   = 1;
				clip_stack[0] = '{left: '0, top: '0, width: scr_w, height: scr_h};
			end
			default: ;
		endcase
		if (stack_count > 0) o.clip = clip_stack[stack_count-1];
		o.depth = crs_pkg::DEPTH_W'(stack_count);
		return o;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		clip_outcome_t want;
		if (!arst_n) begin
			cam_x       = '0;
			cam_y       = '0;
			scr_w       = crs_pkg::SCREEN_W_RST;
			scr_h       = crs_pkg::SCREEN_H_RST;
			stack_count = 0;
			pending_clips.delete();
			pending_count = 0;
		end else begin
			// An item taken at this edge still sees the old register values.
			if (item_valid && !item_stall)
				pending_clips.push_back(apply_clip_op(opcode, rect_left, rect_top,
					rect_width, rect_height));
			if (cfg_we) begin
				case (crs_pkg::cfg_idx_t'(cfg_index))
					crs_pkg::CFG_CAMERA_X:      cam_x = cfg_data;
					crs_pkg::CFG_CAMERA_Y:      cam_y = cfg_data;
					crs_pkg::CFG_SCREEN_WIDTH:  scr_w = cfg_data[crs_pkg::CLIP_W-1:0];
					crs_pkg::CFG_SCREEN_HEIGHT: scr_h = cfg_data[crs_pkg::CLIP_W-1:0];
					default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				if (pending_clips.size() == 0) begin
					fail_count++;
					$display("%0t: result transfer with no result expected", $time);
				end else begin
					want = pending_clips.pop_front();
					check_field("clip_left", want.clip.left, clip_left);
					check_field("clip_top", want.clip.top, clip_top);
					check_field("clip_width", want.clip.width, clip_width);
					check_field("clip_height", want.clip.height, clip_height);
					check_field("depth", want.depth, depth);
					check_field("status", want.refused, status);
				end
			end
			pending_count = pending_clips.size();
		end
	end

endmodule

### dv/clip_rect_stack_core_tb.sv
// Testbench top for the clip rectangle stack: stimulus, idling, watchdog and verdict.
module clip_rect_stack_core_tb ();
	timeunit 1ns;
	timeprecision 1ps;

	// Opcode that the block must ignore.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// Cycles without any transfer or register write before the run is declared hung.
	localparam int IDLE_LIMIT = 2000;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               cfg_we = 1'b0;
	logic [1:0]                         cfg_index = '0;
	logic [crs_pkg::CFG_W-1:0]          cfg_data = '0;
	logic                               item_valid = 1'b0;
	logic [1:0]                         opcode = '0;
	logic [crs_pkg::COORD_W-1:0]        rect_left = '0;
	logic [crs_pkg::COORD_W-1:0]        rect_top = '0;
	logic [crs_pkg::COORD_W-1:0]        rect_width = '0;
	logic [crs_pkg::COORD_W-1:0]        rect_height = '0;
	logic                               result_stall = 1'b0;
	wire logic                          item_stall;
	wire logic                          result_valid;
	wire logic [crs_pkg::CLIP_W-1:0]    clip_left, clip_top, clip_width, clip_height;
	wire logic [crs_pkg::DEPTH_W-1:0]   depth;
	wire logic                          status;
	int                                 errors;
	int                                 outstanding;

	// Shadow of the registers, used only to aim pushes at the visible screen.
	logic [31:0]               aim_cam_x = '0;
	logic [31:0]               aim_cam_y = '0;
	int                        aim_w = 320;
	int                        aim_h = 240;
	// When set, both sides run back to back with no idle cycles.
	bit                        no_gaps = 1'b0;
	int                        idle_cycles = 0;

	always #2 clk = ~clk;

	clip_rect_stack_core uut (
		.clk, .arst_n,
		.cfg_we, .cfg_index, .cfg_data,
		.item_valid, .item_stall, .opcode,
		.rect_left, .rect_top, .rect_width, .rect_height,
		.result_valid, .result_stall,
		.clip_left, .clip_top, .clip_width, .clip_height, .depth, .status
	);

	clip_rect_stack_checker chk (
		.clk, .arst_n,
		.cfg_we, .cfg_index, .cfg_data,
		.item_valid, .item_stall, .opcode,
		.rect_left, .rect_top, .rect_width, .rect_height,
		.result_valid, .result_stall,
		.clip_left, .clip_top, .clip_width, .clip_height, .depth, .status,
		.errors, .outstanding
	);

	// Watchdog: any transfer or register write counts as progress.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result side: stall a random number of cycles, then take one transfer.
	initial begin
		int hold;
		wait (arst_n);
		forever begin
			@(negedge clk);
			hold = no_gaps ? 0 : $urandom_range(0, 10);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	// Offer one item after a random gap and hold it until it transfers.
	task automatic issue_item(logic [1:0] op, logic [31:0] l, logic [31:0] t,
			logic [31:0] w, logic [31:0] h);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 10);
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		opcode      <= op;
		rect_left   <= l;
		rect_top    <= t;
		rect_width  <= w;
		rect_height <= h;
		item_valid  <= 1'b1;
		do @(posedge clk); while (item_stall);
	endtask

	// Drop valid and hold off until every result has come back.
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(crs_pkg::cfg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Load all four registers; upper bits of the screen words are random junk.
	task automatic configure(logic [31:0] cx, logic [31:0] cy, int sw, int sh);
		logic [31:0] junk;
		junk = $urandom;
		write_reg(crs_pkg::CFG_CAMERA_X, cx);
		write_reg(crs_pkg::CFG_CAMERA_Y, cy);
		write_reg(crs_pkg::CFG_SCREEN_WIDTH,
			{junk[31:crs_pkg::CLIP_W], crs_pkg::CLIP_W'(sw)});
		write_reg(crs_pkg::CFG_SCREEN_HEIGHT,
			{junk[crs_pkg::CLIP_W-1:0], junk[31:28], crs_pkg::CLIP_W'(sh)});
		aim_cam_x = cx;
		aim_cam_y = cy;
		aim_w     = sw;
		aim_h     = sh;
	endtask

	function automatic logic [31:0] corner_val();
		case ($urandom_range(0, 3))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h0000_0000;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	// Mostly a coordinate around the visible area, sometimes corners or noise.
	function automatic logic [31:0] pick_pos(logic [31:0] cam, int span);
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) return cam + $urandom_range(0, span + 32) - 32'd16;
		if (r == 7) return corner_val();
		return $urandom;
	endfunction

	function automatic logic [31:0] pick_len(int span);
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return $urandom_range(0, span + 8);
		if (r == 6) return -$urandom_range(1, 100);
		if (r == 7) return corner_val();
		return $urandom;
	endfunction

	task automatic run_random(int count);
		logic [1:0] op;
		int         pick;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
			// Pause once per phase until the block has drained.
			if (i == count / 2) settle();
			pick = $urandom_range(0, 99);
			if (pick < 50) op = crs_pkg::OP_PUSH;
			else if (pick < 80) op = crs_pkg::OP_POP;
			else if (pick < 92) op = crs_pkg::OP_RESET;
			else op = OP_UNUSED;
			if (op == crs_pkg::OP_PUSH)
				issue_item(op, pick_pos(aim_cam_x, aim_w), pick_pos(aim_cam_y, aim_h),
					pick_len(aim_w), pick_len(aim_h));
			else
				issue_item(op, $urandom, $urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty stack: pop and the unused opcode do nothing.
		issue_item(crs_pkg::OP_POP, '0, '0, '0, '0);
		issue_item(OP_UNUSED, '1, '1, '1, '1);
		// Push onto the empty stack is clipped by the screen only.
		issue_item(crs_pkg::OP_PUSH, 32'd10, 32'd20, 32'd100, 32'd50);
		// Negative width collapses to an empty rectangle.
		issue_item(crs_pkg::OP_PUSH, 32'd0, 32'd0, -32'sd5, 32'd10);
		issue_item(crs_pkg::OP_POP, '0, '0, '0, '0);
		// Pops at the base entry leave it in place.
		issue_item(crs_pkg::OP_POP, '0, '0, '0, '0);
		issue_item(crs_pkg::OP_POP, '0, '0, '0, '0);
		issue_item(crs_pkg::OP_RESET, '0, '0, '0, '0);
		// Rectangle larger than the screen, then extreme edges.
		issue_item(crs_pkg::OP_PUSH, -32'sd100, -32'sd100, 32'h7fff_ffff, 32'h7fff_ffff);
		issue_item(crs_pkg::OP_PUSH, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
			32'h7fff_ffff);
		issue_item(crs_pkg::OP_POP, '0, '0, '0, '0);
		issue_item(crs_pkg::OP_PUSH, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff);
		issue_item(crs_pkg::OP_PUSH, 32'hffff_ffff, 32'hffff_ffff, 32'd2, 32'h8000_0000);
		issue_item(crs_pkg::OP_POP, '0, '0, '0, '0);
		// Fill to the top, then one push that must be refused.
		for (int i = 0; i < 13; i++)
			issue_item(crs_pkg::OP_PUSH, 32'(i * 7), 32'(i * 5), 32'd300, 32'd200);
		issue_item(crs_pkg::OP_PUSH, 32'd0, 32'd0, 32'd10, 32'd10);
		issue_item(OP_UNUSED, '0, '0, '0, '0);
		run_random(110);
		settle();

		// Sweep register settings, extremes included.
		configure(32'd100, -32'sd50, 640, 480);
		run_random(120);
		settle();
		configure(32'h8000_0000, 32'h7fff_ffff, 8192, 8192);
		run_random(120);
		settle();
		configure(32'h7fff_ffff, 32'h8000_0000, 1, 1);
		run_random(120);
		settle();
		configure($urandom, $urandom, 0, 100);
		run_random(120);
		settle();
		configure(32'd0, 32'd0, 16383, 8192);
		run_random(120);
		settle();
		configure($urandom_range(0, 2000) - 32'd1000, $urandom_range(0, 2000) - 32'd1000,
			$urandom_range(1, 1024), $urandom_range(1, 1024));
		run_random(120);
		settle();
		repeat (4) @(posedge clk);

		if (errors == 0 && outstanding == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### files.f
src/crs_pkg.sv
src/clip_rect_stack_core.sv
dv/clip_rect_stack_checker.sv
dv/clip_rect_stack_core_tb.sv
